// File: hdl/point_in_triangle_test_top_macros.svh
`ifndef POINT_IN_TRIANGLE_TEST_TOP_MACROS_SVH
`define POINT_IN_TRIANGLE_TEST_TOP_MACROS_SVH

// implication checked on every edge outside reset
`define PITT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never hold
`define PITT_NEVER(lbl, cond, msg) \
  `PITT_ASSERT(lbl, 1'b1, !(cond), msg)

`endif

// File: hdl/pitt_pkg.sv
`timescale 1ns / 1ps

package pitt_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;

  // edge vectors: C-A, B-A, P-A
  localparam int unsigned VEC_V0   = 0;
  localparam int unsigned VEC_V1   = 1;
  localparam int unsigned VEC_V2   = 2;
  localparam int unsigned NUM_VECS = 3;
  localparam int unsigned NUM_AXES = 3;

  localparam int unsigned DOT_00   = 0;
  localparam int unsigned DOT_01   = 1;
  localparam int unsigned DOT_02   = 2;
  localparam int unsigned DOT_11   = 3;
  localparam int unsigned DOT_12   = 4;
  localparam int unsigned NUM_DOTS = 5;

  localparam int unsigned DOT_LHS [NUM_DOTS] = '{VEC_V0, VEC_V0, VEC_V0, VEC_V1, VEC_V1};
  localparam int unsigned DOT_RHS [NUM_DOTS] = '{VEC_V0, VEC_V1, VEC_V2, VEC_V1, VEC_V2};

  // D = d00*d11 - d01*d01, U = d11*d02 - d01*d12, V = d00*d12 - d01*d02
  localparam int unsigned PROD_D00_D11 = 0;
  localparam int unsigned PROD_D01_D01 = 1;
  localparam int unsigned PROD_D11_D02 = 2;
  localparam int unsigned PROD_D01_D12 = 3;
  localparam int unsigned PROD_D00_D12 = 4;
  localparam int unsigned PROD_D01_D02 = 5;
  localparam int unsigned NUM_PRODS    = 6;

  localparam int unsigned MUL_LHS [NUM_PRODS] = '{DOT_00, DOT_01, DOT_11, DOT_01, DOT_00, DOT_01};
  localparam int unsigned MUL_RHS [NUM_PRODS] = '{DOT_11, DOT_01, DOT_02, DOT_12, DOT_12, DOT_02};

endpackage

// File: hdl/pitt_front.sv
`timescale 1ns / 1ps

module pitt_front #(
  parameter int unsigned CoordWidth = pitt_pkg::COORD_WIDTH_DEF,
  localparam int unsigned DiffWidth = CoordWidth + 1,
  localparam int unsigned ProdWidth = 2 * DiffWidth,
  localparam int unsigned DotWidth  = ProdWidth + 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [CoordWidth-1:0] a_i [pitt_pkg::NUM_AXES],
  input  logic signed [CoordWidth-1:0] b_i [pitt_pkg::NUM_AXES],
  input  logic signed [CoordWidth-1:0] c_i [pitt_pkg::NUM_AXES],
  input  logic signed [CoordWidth-1:0] p_i [pitt_pkg::NUM_AXES],
  input  logic                        valid_i,
  output logic                        stall_o,
  output logic signed [DotWidth-1:0]  d_o [pitt_pkg::NUM_DOTS],
  output logic                        valid_o,
  input  logic                        stall_i
);

  logic [2:0] vld_q;
  logic [2:0] rdy;

  logic signed [DiffWidth-1:0] v_q [pitt_pkg::NUM_VECS][pitt_pkg::NUM_AXES];
  logic signed [ProdWidth-1:0] p_q [pitt_pkg::NUM_DOTS][pitt_pkg::NUM_AXES];
  logic signed [DotWidth-1:0]  d_q [pitt_pkg::NUM_DOTS];

  assign rdy[2]  = !vld_q[2] || !stall_i;
  assign rdy[1]  = !vld_q[1] || rdy[2];
  assign rdy[0]  = !vld_q[0] || rdy[1];
  assign stall_o = !rdy[0];
  assign valid_o = vld_q[2];
  assign d_o     = d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      for (int i = 0; i < pitt_pkg::NUM_AXES; i++) begin
        v_q[pitt_pkg::VEC_V0][i] <= DiffWidth'(c_i[i]) - DiffWidth'(a_i[i]);
        v_q[pitt_pkg::VEC_V1][i] <= DiffWidth'(b_i[i]) - DiffWidth'(a_i[i]);
        v_q[pitt_pkg::VEC_V2][i] <= DiffWidth'(p_i[i]) - DiffWidth'(a_i[i]);
      end
    end
    if (rdy[1]) begin
      for (int k = 0; k < pitt_pkg::NUM_DOTS; k++) begin
        for (int i = 0; i < pitt_pkg::NUM_AXES; i++) begin
          p_q[k][i] <= ProdWidth'(v_q[pitt_pkg::DOT_LHS[k]][i])
                     * ProdWidth'(v_q[pitt_pkg::DOT_RHS[k]][i]);
        end
      end
    end
    if (rdy[2]) begin
      for (int k = 0; k < pitt_pkg::NUM_DOTS; k++) begin
        d_q[k] <= DotWidth'(p_q[k][0]) + DotWidth'(p_q[k][1]) + DotWidth'(p_q[k][2]);
      end
    end
  end

endmodule

// File: hdl/pitt_mul.sv
`timescale 1ns / 1ps
`include "point_in_triangle_test_top_macros.svh"

module pitt_mul #(
  parameter int unsigned DotWidth = 2 * (pitt_pkg::COORD_WIDTH_DEF + 1) + 2,
  localparam int unsigned ProdWidth = 2 * DotWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [DotWidth-1:0]  d_i [pitt_pkg::NUM_DOTS],
  input  logic                        valid_i,
  output logic                        stall_o,
  output logic signed [ProdWidth-1:0] prod_o [pitt_pkg::NUM_PRODS],
  output logic                        valid_o,
  input  logic                        stall_i
);

  localparam int unsigned LoWidth    = DotWidth / 2;
  localparam int unsigned HiWidth    = DotWidth - LoWidth;
  localparam int unsigned CrossWidth = HiWidth + LoWidth + 1;

  logic [2:0] vld_q;
  logic [2:0] rdy;

  assign rdy[2]  = !vld_q[2] || !stall_i;
  assign rdy[1]  = !vld_q[1] || rdy[2];
  assign rdy[0]  = !vld_q[0] || rdy[1];
  assign stall_o = !rdy[0];
  assign valid_o = vld_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  // split each operand into a signed upper half and an unsigned lower half
  for (genvar k = 0; k < pitt_pkg::NUM_PRODS; k++) begin : g_prod
    logic signed [HiWidth-1:0]      xh, yh;
    logic        [LoWidth-1:0]      xl, yl;
    logic signed [2*HiWidth-1:0]    hh_q;
    logic signed [CrossWidth-1:0]   hl_q, lh_q;
    logic        [2*LoWidth-1:0]    ll_q;
    logic signed [CrossWidth:0]     cross_q;
    logic signed [ProdWidth-1:0]    hhll_q;
    logic signed [ProdWidth-1:0]    prod_q;

    assign xh = d_i[pitt_pkg::MUL_LHS[k]][DotWidth-1:LoWidth];
    assign xl = d_i[pitt_pkg::MUL_LHS[k]][LoWidth-1:0];
    assign yh = d_i[pitt_pkg::MUL_RHS[k]][DotWidth-1:LoWidth];
    assign yl = d_i[pitt_pkg::MUL_RHS[k]][LoWidth-1:0];

    always_ff @(posedge clk_i) begin
      if (rdy[0]) begin
        hh_q <= (2*HiWidth)'(xh) * (2*HiWidth)'(yh);
        hl_q <= CrossWidth'(xh) * CrossWidth'(signed'({1'b0, yl}));
        lh_q <= CrossWidth'(signed'({1'b0, xl})) * CrossWidth'(yh);
        ll_q <= (2*LoWidth)'(xl) * (2*LoWidth)'(yl);
      end
      if (rdy[1]) begin
        cross_q <= (CrossWidth+1)'(hl_q) + (CrossWidth+1)'(lh_q);
        hhll_q  <= {hh_q, ll_q};
      end
      if (rdy[2]) begin
        prod_q <= hhll_q + (ProdWidth'(cross_q) <<< LoWidth);
      end
    end

    assign prod_o[k] = prod_q;
  end

  `PITT_ASSERT(a_square_nonneg, valid_o, !prod_o[pitt_pkg::PROD_D01_D01][ProdWidth-1], "d01 squared negative")
  `PITT_ASSERT(a_norms_nonneg, valid_o, !prod_o[pitt_pkg::PROD_D00_D11][ProdWidth-1], "d00 d11 product negative")

endmodule

// File: hdl/pitt_decide.sv
`timescale 1ns / 1ps

module pitt_decide #(
  parameter int unsigned ProdWidth = 4 * (pitt_pkg::COORD_WIDTH_DEF + 1) + 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [ProdWidth-1:0] prod_i [pitt_pkg::NUM_PRODS],
  input  logic                        valid_i,
  output logic                        stall_o,
  output logic                        inside_o,
  output logic                        degen_o,
  output logic                        valid_o,
  input  logic                        stall_i
);

  localparam int unsigned NumWidth = ProdWidth + 1;
  localparam int unsigned SumWidth = NumWidth + 2;

  logic [2:0] vld_q;
  logic [2:0] rdy;

  logic signed [NumWidth-1:0] den_q, un_q, vn_q;
  logic signed [SumWidth-1:0] sum_q, den_x_q;
  logic                       degen_q, un_neg_q, vn_neg_q;
  logic signed [SumWidth-1:0] margin;
  logic                       inside_q, degen_out_q;

  assign rdy[2]   = !vld_q[2] || !stall_i;
  assign rdy[1]   = !vld_q[1] || rdy[2];
  assign rdy[0]   = !vld_q[0] || rdy[1];
  assign stall_o  = !rdy[0];
  assign valid_o  = vld_q[2];
  assign inside_o = inside_q;
  assign degen_o  = degen_out_q;

  assign margin = sum_q - den_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= valid_i;
      if (rdy[1]) vld_q[1] <= vld_q[0];
      if (rdy[2]) vld_q[2] <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      den_q <= NumWidth'(prod_i[pitt_pkg::PROD_D00_D11])
             - NumWidth'(prod_i[pitt_pkg::PROD_D01_D01]);
      un_q  <= NumWidth'(prod_i[pitt_pkg::PROD_D11_D02])
             - NumWidth'(prod_i[pitt_pkg::PROD_D01_D12]);
      vn_q  <= NumWidth'(prod_i[pitt_pkg::PROD_D00_D12])
             - NumWidth'(prod_i[pitt_pkg::PROD_D01_D02]);
    end
    if (rdy[1]) begin
      sum_q    <= SumWidth'(un_q) + SumWidth'(vn_q);
      den_x_q  <= SumWidth'(den_q);
      degen_q  <= (den_q == '0);
      un_neg_q <= un_q[NumWidth-1];
      vn_neg_q <= vn_q[NumWidth-1];
    end
    if (rdy[2]) begin
      inside_q    <= !degen_q && !un_neg_q && !vn_neg_q && margin[SumWidth-1];
      degen_out_q <= degen_q;
    end
  end

endmodule

// File: hdl/point_in_triangle_test_top.sv
`timescale 1ns / 1ps
`include "point_in_triangle_test_top_macros.svh"

// Barycentric point-in-triangle test: takes vertices A, B, C and point P as
// signed grid coordinates and reports inside when U >= 0, V >= 0 and U + V < D,
// all exact integers, with no division; a zero denominator (collinear or
// coincident vertices) gives degenerate = 1 and inside = 0. A point off the
// plane is judged by its projection. One beat is accepted every clock cycle
// while in_stall_o is low; the design has nine register stages (edge vectors,
// component products, dot sums, three-stage split wide multiply, numerators,
// sum, compare). Bubbles close up under backpressure; in_stall_o rises only
// while out_valid_o is held off by out_stall_i and every stage is full.

module point_in_triangle_test_top #(
  parameter int unsigned COORD_WIDTH = pitt_pkg::COORD_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_a_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_b_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_c_z_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         inside_res_o,
  output logic                         degenerate_o
);

  localparam int unsigned DotWidth  = 2 * (COORD_WIDTH + 1) + 2;
  localparam int unsigned ProdWidth = 2 * DotWidth;

  logic signed [COORD_WIDTH-1:0] a_v [pitt_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] b_v [pitt_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] c_v [pitt_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] p_v [pitt_pkg::NUM_AXES];

  logic signed [DotWidth-1:0]  dot   [pitt_pkg::NUM_DOTS];
  logic signed [ProdWidth-1:0] prod  [pitt_pkg::NUM_PRODS];
  logic                        dot_valid, dot_stall;
  logic                        prod_valid, prod_stall;

  assign a_v = '{vertex_a_x_i, vertex_a_y_i, vertex_a_z_i};
  assign b_v = '{vertex_b_x_i, vertex_b_y_i, vertex_b_z_i};
  assign c_v = '{vertex_c_x_i, vertex_c_y_i, vertex_c_z_i};
  assign p_v = '{point_x_i, point_y_i, point_z_i};

  pitt_front #(
    .CoordWidth (COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .a_i     (a_v),
    .b_i     (b_v),
    .c_i     (c_v),
    .p_i     (p_v),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .d_o     (dot),
    .valid_o (dot_valid),
    .stall_i (dot_stall)
  );

  pitt_mul #(
    .DotWidth (DotWidth)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .d_i     (dot),
    .valid_i (dot_valid),
    .stall_o (dot_stall),
    .prod_o  (prod),
    .valid_o (prod_valid),
    .stall_i (prod_stall)
  );

  pitt_decide #(
    .ProdWidth (ProdWidth)
  ) u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .prod_i   (prod),
    .valid_i  (prod_valid),
    .stall_o  (prod_stall),
    .inside_o (inside_res_o),
    .degen_o  (degenerate_o),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i)
  );

  `PITT_NEVER(a_degen_not_inside, out_valid_o && degenerate_o && inside_res_o, "degenerate beat flagged inside")
  `PITT_ASSERT(a_stall_only_when_blocked, in_stall_o, out_valid_o && out_stall_i, "input stalled while output free")

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CW = pitt_pkg::COORD_WIDTH_DEF;
  localparam int RANDOM_ITEMS   = 1950;
  localparam int HOLD_AT        = 400;
  localparam int HOLD_CYCLES    = 80;
  localparam int QUIET_FROM     = 1500;
  localparam int QUIET_TO       = 1900;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 20;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [127:0]   wide_t;

  typedef struct packed {
    coord_t [2:0] a;
    coord_t [2:0] b;
    coord_t [2:0] c;
    coord_t [2:0] p;
  } tri_query_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } verdict_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       out_stall = 1'b0;
  tri_query_t offered = '0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       inside_res_o;
  logic       degenerate_o;

  tri_query_t query_q[$];
  verdict_t   verdict_q[$];
  int         err_count = 0;
  int         cycle_no = 0;
  int         idle_cycles = 0;
  int         results_seen = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  wire        quiet = (cycle_no >= QUIET_FROM) && (cycle_no < QUIET_TO);

  always #6 clk_i = ~clk_i;

  point_in_triangle_test_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .vertex_a_x_i (offered.a[0]),
    .vertex_a_y_i (offered.a[1]),
    .vertex_a_z_i (offered.a[2]),
    .vertex_b_x_i (offered.b[0]),
    .vertex_b_y_i (offered.b[1]),
    .vertex_b_z_i (offered.b[2]),
    .vertex_c_x_i (offered.c[0]),
    .vertex_c_y_i (offered.c[1]),
    .vertex_c_z_i (offered.c[2]),
    .point_x_i    (offered.p[0]),
    .point_y_i    (offered.p[1]),
    .point_z_i    (offered.p[2]),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .inside_res_o (inside_res_o),
    .degenerate_o (degenerate_o)
  );

  // exact integer barycentric test, no division
  function automatic verdict_t classify_point(tri_query_t q);
    longint   e0 [3];
    longint   e1 [3];
    longint   e2 [3];
    longint   d00, d01, d02, d11, d12;
    wide_t    den, un, vn;
    verdict_t r;
    for (int i = 0; i < 3; i++) begin
      e0[i] = longint'($signed(q.c[i])) - longint'($signed(q.a[i]));
      e1[i] = longint'($signed(q.b[i])) - longint'($signed(q.a[i]));
      e2[i] = longint'($signed(q.p[i])) - longint'($signed(q.a[i]));
    end
    d00 = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
    d01 = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
    d02 = e0[0] * e2[0] + e0[1] * e2[1] + e0[2] * e2[2];
    d11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
    d12 = e1[0] * e2[0] + e1[1] * e2[1] + e1[2] * e2[2];
    den = wide_t'(d00) * wide_t'(d11) - wide_t'(d01) * wide_t'(d01);
    un  = wide_t'(d11) * wide_t'(d02) - wide_t'(d01) * wide_t'(d12);
    vn  = wide_t'(d00) * wide_t'(d12) - wide_t'(d01) * wide_t'(d02);
    r.degenerate = (den == 0);
    r.inside_res = !r.degenerate && (un >= 0) && (vn >= 0) && (un + vn < den);
    return r;
  endfunction

  function automatic void add_query(int ax, int ay, int az, int bx, int by, int bz,
                                    int cx, int cy, int cz, int px, int py, int pz);
    tri_query_t q;
    q.a[0] = coord_t'(ax); q.a[1] = coord_t'(ay); q.a[2] = coord_t'(az);
    q.b[0] = coord_t'(bx); q.b[1] = coord_t'(by); q.b[2] = coord_t'(bz);
    q.c[0] = coord_t'(cx); q.c[1] = coord_t'(cy); q.c[2] = coord_t'(cz);
    q.p[0] = coord_t'(px); q.p[1] = coord_t'(py); q.p[2] = coord_t'(pz);
    query_q = {query_q, q};
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(7))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      6: return 32767;
      default: return int'($urandom);
    endcase
  endfunction

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o)
        verdict_q = {verdict_q, classify_point(offered)};
      if (!in_valid || !in_stall_o) begin
        if (query_q.size() != 0 && (quiet || $urandom_range(99) >= 19)) begin
          offered  <= query_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result beat and drives the stall, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        results_seen <= results_seen + 1;
        if (verdict_q.size() == 0) begin
          $error("result beat with nothing expected: inside_res %0b degenerate %0b",
                 inside_res_o, degenerate_o);
          err_count = err_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (inside_res_o !== want.inside_res) begin
            $error("inside_res: expected %0b, got %0b", want.inside_res, inside_res_o);
            err_count = err_count + 1;
          end
          if (degenerate_o !== want.degenerate) begin
            $error("degenerate: expected %0b, got %0b", want.degenerate, degenerate_o);
            err_count = err_count + 1;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 19);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[point_in_triangle_test_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int a [3];
    int b [3];
    int c [3];
    int p [3];
    int sel, s, t, k, pick, jit;

    add_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_query(32767, 32767, 32767, 32767, 32767, 32767,
              32767, 32767, 32767, 32767, 32767, 32767);
    add_query(-32768, -32768, -32768, -32768, -32768, -32768,
              -32768, -32768, -32768, -32768, -32768, -32768);
    add_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 2, 2, 0);
    add_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 0, 0, 0);
    add_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 10, 0, 0);
    add_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 0, 10, 0);
    add_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 5, 0, 0);
    add_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 5, 5, 0);
    add_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 2, 2, 500);
    add_query(0, 0, 0, 10, 0, 0, 0, 10, 0, -1, 2, 0);
    add_query(0, 0, 0, 10, 0, 0, 0, 10, 0, 2, -1, 0);
    add_query(0, 0, 0, 1, 2, 3, 2, 4, 6, 1, 2, 3);
    add_query(5, -7, 9, 5, -7, 9, 100, 200, -300, 6, -6, 9);
    add_query(-32768, -32768, -32768, 32767, -32768, 32767,
              -32768, 32767, 32767, 0, 0, 0);
    add_query(-32768, -32768, -32768, 32767, -32768, 32767,
              -32768, 32767, 32767, 32767, 32767, -32768);
    add_query(-32768, 0, 0, 32767, 0, 0, 32767, 1, 0, 0, 0, 0);
    add_query(32767, 32767, 32767, -32768, -32768, 32767,
              -32768, 32767, -32768, -32768, -32768, -32768);
    add_query(0, 0, 0, 4, 0, 0, 0, 4, 0, -32768, -32768, -32768);
    add_query(21845, -21846, 21845, -21846, 21845, -21846,
              21845, 21845, -21846, -21846, -21846, 21845);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel  = $urandom_range(99);
      s    = $urandom_range(256);
      t    = $urandom_range(256 - s);
      k    = int'($urandom_range(10)) - 5;
      pick = $urandom_range(5);
      for (int i = 0; i < 3; i++) begin
        a[i] = int'($urandom_range(20000)) - 10000;
        b[i] = a[i] + int'($urandom_range(20000)) - 10000;
        c[i] = a[i] + int'($urandom_range(20000)) - 10000;
        jit  = (sel < 10) ? int'($urandom_range(600)) - 300 : 0;
        p[i] = a[i] + (s * (b[i] - a[i]) + t * (c[i] - a[i])) / 256 + jit;
        if (sel >= 45 && sel < 60) begin
          a[i] = int'($urandom);
          b[i] = int'($urandom);
          c[i] = int'($urandom);
          p[i] = int'($urandom);
        end else if (sel >= 60 && sel < 75) begin
          a[i] = int'($urandom_range(6)) - 3;
          b[i] = int'($urandom_range(6)) - 3;
          c[i] = int'($urandom_range(6)) - 3;
          p[i] = int'($urandom_range(6)) - 3;
        end else if (sel >= 75 && sel < 85) begin
          // collinear or coincident vertices
          a[i] = int'($urandom_range(2000)) - 1000;
          b[i] = a[i] + int'($urandom_range(200)) - 100;
          c[i] = a[i] + k * (b[i] - a[i]);
          p[i] = int'($urandom_range(2000)) - 1000;
        end else if (sel >= 85 && sel < 95) begin
          a[i] = pick_extreme();
          b[i] = pick_extreme();
          c[i] = pick_extreme();
          p[i] = pick_extreme();
        end else if (sel >= 95) begin
          case (pick)
            0: p[i] = a[i];
            1: p[i] = b[i];
            2: p[i] = c[i];
            3: p[i] = (a[i] + b[i]) / 2;
            4: p[i] = (b[i] + c[i]) / 2;
            default: p[i] = (a[i] + c[i]) / 2;
          endcase
        end
      end
      add_query(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2], p[0], p[1], p[2]);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (query_q.size() != 0 || in_valid) @(negedge clk_i);
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("[point_in_triangle_test_top] OK");
    end else begin
      $display("[point_in_triangle_test_top] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/pitt_pkg.sv
hdl/pitt_front.sv
hdl/pitt_mul.sv
hdl/pitt_decide.sv
hdl/point_in_triangle_test_top.sv
tb/sv/tb_top.sv
